// ----- rtl/core/vic_pkg.sv -----
// package: constants, register offsets and command type of the vectored interrupt controller
`timescale 1ns / 1ps
`default_nettype none
package vic_pkg;

  localparam int NUM_SRC      = 32;
  localparam int SRC_W        = 5;
  localparam int STACK_LEVELS = 8;
  localparam int DEPTH_W      = $clog2(STACK_LEVELS + 1);
  localparam int STK_IDX_W    = (STACK_LEVELS > 1) ? $clog2(STACK_LEVELS) : 1;
  localparam int PRIO_W       = 3;
  localparam int NUM_PRIO     = 8;
  localparam int OP_W         = 2;
  localparam int ADDR_W       = 12;
  localparam int DATA_W       = 32;

  localparam logic [OP_W-1:0] OP_READ  = 2'd0;
  localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OP_W-1:0] OP_LINE  = 2'd2;

  localparam int MODE_EDGE_BIT  = 5;
  localparam int MODE_LEVEL_BIT = 6;

  localparam logic [ADDR_W-1:0] ADDR_SVR   = 12'h080;
  localparam logic [ADDR_W-1:0] ADDR_IVR   = 12'h100;
  localparam logic [ADDR_W-1:0] ADDR_FVR   = 12'h104;
  localparam logic [ADDR_W-1:0] ADDR_ISR   = 12'h108;
  localparam logic [ADDR_W-1:0] ADDR_IPR   = 12'h10c;
  localparam logic [ADDR_W-1:0] ADDR_IMR   = 12'h110;
  localparam logic [ADDR_W-1:0] ADDR_CISR  = 12'h114;
  localparam logic [ADDR_W-1:0] ADDR_IECR  = 12'h120;
  localparam logic [ADDR_W-1:0] ADDR_IDCR  = 12'h124;
  localparam logic [ADDR_W-1:0] ADDR_ICCR  = 12'h128;
  localparam logic [ADDR_W-1:0] ADDR_ISCR  = 12'h12c;
  localparam logic [ADDR_W-1:0] ADDR_EOICR = 12'h130;
  localparam logic [ADDR_W-1:0] ADDR_SPU   = 12'h134;
  localparam logic [ADDR_W-1:0] ADDR_DCR   = 12'h138;
  localparam logic [ADDR_W-1:0] ADDR_FFER  = 12'h140;
  localparam logic [ADDR_W-1:0] ADDR_FFDR  = 12'h144;
  localparam logic [ADDR_W-1:0] ADDR_FFSR  = 12'h148;

  typedef struct packed {
    logic capture;
    logic search;
    logic exec;
    logic check;
  } vic_cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/vectored_interrupt_controller.sv -----
// top level: vectored interrupt controller, controller plus datapath
// sequence: an accepted transaction passes through priority search, register update and status check
//   before its result is registered; the status check waits while the result register is stalled
// a new transaction is accepted only after the four-step sequencer returns to idle
// reset: asynchronous active low; control state, configuration registers, masks and the level stack
//   clear (captured and result registers are not reset), source 0 starts in the fast mask
`timescale 1ns / 1ps
`default_nettype none
module vectored_interrupt_controller (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [vic_pkg::OP_W-1:0]     operation_i,
  input  wire logic [vic_pkg::ADDR_W-1:0]   address_i,
  input  wire logic [vic_pkg::DATA_W-1:0]   write_data_i,
  input  wire logic [vic_pkg::SRC_W-1:0]    source_line_i,
  input  wire logic                         line_level_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic      [vic_pkg::DATA_W-1:0]   read_data_o,
  output logic                              irq_out_o
);
  import vic_pkg::*;

  vic_cmd_t cmd;

  vic_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  vic_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .source_line_i (source_line_i),
    .line_level_i  (line_level_i),
    .read_data_o   (read_data_o),
    .irq_out_o     (irq_out_o)
  );

endmodule
`default_nettype wire

// ----- rtl/core/vic_ctrl.sv -----
// controller: sequences capture, priority search, register update and status check
`timescale 1ns / 1ps
`default_nettype none
module vic_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output vic_pkg::vic_cmd_t  cmd_o
);
  import vic_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_CHK  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    out_valid_d   = out_valid_q && out_stall_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd_o.search = 1'b1;
        state_d      = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_CHK;
      end
      S_CHK: begin
        // result waits here until the output register is free
        if (slot_free) begin
          cmd_o.check = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/vic_dp.sv -----
// datapath: source registers, masks, priority stack, priority search and read mux
`timescale 1ns / 1ps
`default_nettype none
module vic_dp (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire vic_pkg::vic_cmd_t            cmd_i,
  input  wire logic [vic_pkg::OP_W-1:0]     operation_i,
  input  wire logic [vic_pkg::ADDR_W-1:0]   address_i,
  input  wire logic [vic_pkg::DATA_W-1:0]   write_data_i,
  input  wire logic [vic_pkg::SRC_W-1:0]    source_line_i,
  input  wire logic                         line_level_i,
  output logic      [vic_pkg::DATA_W-1:0]   read_data_o,
  output logic                              irq_out_o
);
  import vic_pkg::*;

  localparam logic [DATA_W-1:0] SRC_MASK = DATA_W'(32'hFFFF_FFFF >> (32 - NUM_SRC));

  // captured transaction
  logic [OP_W-1:0]   op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [DATA_W-1:0] wd_q;
  logic [SRC_W-1:0]  src_q;
  logic              lvl_q;

  // architectural state
  logic [DATA_W-1:0]    smr_q [NUM_SRC];
  logic [DATA_W-1:0]    svr_q [NUM_SRC];
  logic [NUM_SRC-1:0]   en_q, pend_q, fast_q;
  logic [SRC_W-1:0]     isr_q;
  logic [1:0]           cs_q, cs_d;
  logic [DATA_W-1:0]    spu_q;
  logic                 dbg_q;
  logic [PRIO_W-1:0]    stk_q [STACK_LEVELS];
  logic [DEPTH_W-1:0]   depth_q;

  // search results and per-transaction flags
  logic                 found_q;
  logic [SRC_W-1:0]     best_q;
  logic [DATA_W-1:0]    rd_q, rd_d;
  logic                 rchk_q, rchk_d;
  logic                 ivr_q;

  logic [NUM_SRC-1:0]   cand, elig, higher, pick, low;
  logic [NUM_SRC-1:0]   m;
  logic [NUM_PRIO-1:0]  lvl_hit;
  logic [PRIO_W-1:0]    best_lvl;
  logic [SRC_W-1:0]     best_idx;
  logic                 cur_vld;
  logic [STK_IDX_W-1:0] top_idx, push_idx;
  logic [PRIO_W-1:0]    cur_lvl;
  logic [DEPTH_W-1:0]   depth_push;
  logic                 in_smr, in_svr, idx_ok, src_ok, fast_any;
  logic [SRC_W-1:0]     idx;

  assign cand    = en_q & pend_q & ~fast_q;
  assign cur_vld = (depth_q != '0);
  assign top_idx = STK_IDX_W'(depth_q - DEPTH_W'(1));
  assign cur_lvl = stk_q[top_idx];
  assign fast_any = |(en_q & pend_q & fast_q);
  // mask writes drop bits of sources that do not exist
  assign m       = wd_q[NUM_SRC-1:0] & SRC_MASK[NUM_SRC-1:0];

  assign in_smr = (addr_q < ADDR_SVR);
  assign in_svr = !in_smr && (addr_q < ADDR_IVR);
  assign idx    = addr_q[SRC_W+1:2];
  assign idx_ok = ({1'b0, idx} < (SRC_W+1)'(NUM_SRC));
  assign src_ok = ({1'b0, src_q} < (SRC_W+1)'(NUM_SRC));

  // eligibility against the current level; empty stack lets every level through
  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      elig[i]   = cand[i] && (!cur_vld || (smr_q[i][PRIO_W-1:0] >= cur_lvl));
      higher[i] = cand[i] && (!cur_vld || (smr_q[i][PRIO_W-1:0] > cur_lvl));
    end
  end

  always_comb begin
    lvl_hit = '0;
    for (int i = 0; i < NUM_SRC; i++) begin
      lvl_hit[smr_q[i][PRIO_W-1:0]] = lvl_hit[smr_q[i][PRIO_W-1:0]] | elig[i];
    end
    best_lvl = '0;
    for (int p = 0; p < NUM_PRIO; p++) begin
      if (lvl_hit[p]) best_lvl = PRIO_W'(p);
    end
  end

  // lowest index among sources at the winning level
  always_comb begin
    for (int i = 0; i < NUM_SRC; i++) begin
      pick[i] = elig[i] && (smr_q[i][PRIO_W-1:0] == best_lvl);
    end
    low      = pick & (~pick + NUM_SRC'(1));
    best_idx = '0;
    for (int i = 0; i < NUM_SRC; i++) begin
      if (low[i]) best_idx = best_idx | SRC_W'(i);
    end
  end

  assign push_idx   = (depth_q < DEPTH_W'(STACK_LEVELS)) ? STK_IDX_W'(depth_q)
                                                         : STK_IDX_W'(STACK_LEVELS - 1);
  assign depth_push = (depth_q < DEPTH_W'(STACK_LEVELS)) ? depth_q + DEPTH_W'(1) : depth_q;

  // read value and whether the transaction re-evaluates the core status
  always_comb begin
    rd_d   = '0;
    rchk_d = 1'b0;
    case (op_q)
      OP_READ: begin
        if (in_smr) begin
          rd_d = idx_ok ? smr_q[idx] : '0;
        end else if (in_svr) begin
          rd_d = idx_ok ? svr_q[idx] : '0;
        end else begin
          case (addr_q)
            ADDR_IVR:  rd_d = (found_q && best_q != '0) ? svr_q[best_q] : spu_q;
            ADDR_FVR:  rd_d = fast_any ? svr_q[0] : spu_q;
            ADDR_ISR:  rd_d = DATA_W'(isr_q);
            ADDR_IPR:  rd_d = DATA_W'(pend_q);
            ADDR_IMR:  rd_d = DATA_W'(en_q);
            ADDR_CISR: rd_d = DATA_W'(cs_q);
            ADDR_FFSR: rd_d = DATA_W'(fast_q);
            default:   rd_d = '0;
          endcase
        end
      end
      OP_WRITE: begin
        if (!in_smr && !in_svr) begin
          case (addr_q)
            ADDR_IECR, ADDR_IDCR, ADDR_ICCR, ADDR_ISCR, ADDR_EOICR,
            ADDR_DCR, ADDR_FFER, ADDR_FFDR: rchk_d = 1'b1;
            default: rchk_d = 1'b0;
          endcase
        end
      end
      OP_LINE: rchk_d = src_ok;
      default: rchk_d = 1'b0;
    endcase
  end

  always_comb begin
    if (rchk_q) begin
      cs_d = {|higher, fast_any};
    end else if (ivr_q) begin
      cs_d = {1'b0, cs_q[0]};
    end else begin
      cs_d = cs_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= operation_i;
      addr_q <= address_i;
      wd_q   <= write_data_i;
      src_q  <= source_line_i;
      lvl_q  <= line_level_i;
    end
    if (cmd_i.search) begin
      found_q <= |elig;
      best_q  <= best_idx;
    end
    if (cmd_i.exec) begin
      rd_q   <= rd_d;
      rchk_q <= rchk_d;
      ivr_q  <= (op_q == OP_READ) && (addr_q == ADDR_IVR);
    end
    if (cmd_i.check) begin
      read_data_o <= rd_q;
      irq_out_o   <= cs_d[1] & ~dbg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SRC; i++) begin
        smr_q[i] <= '0;
        svr_q[i] <= '0;
      end
      for (int k = 0; k < STACK_LEVELS; k++) begin
        stk_q[k] <= '0;
      end
      en_q    <= '0;
      pend_q  <= '0;
      fast_q  <= NUM_SRC'(1);
      isr_q   <= '0;
      cs_q    <= '0;
      spu_q   <= '0;
      dbg_q   <= 1'b0;
      depth_q <= '0;
    end else begin
      if (cmd_i.check) begin
        cs_q <= cs_d;
      end
      if (cmd_i.exec) begin
        case (op_q)
          OP_READ: begin
            if (!in_smr && !in_svr && addr_q == ADDR_IVR && found_q && best_q != '0) begin
              isr_q           <= best_q;
              depth_q         <= depth_push;
              stk_q[push_idx] <= smr_q[best_q][PRIO_W-1:0];
              if (smr_q[best_q][MODE_EDGE_BIT]) begin
                pend_q[best_q] <= 1'b0;
              end
            end
          end
          OP_WRITE: begin
            if (in_smr) begin
              if (idx_ok) smr_q[idx] <= wd_q;
            end else if (in_svr) begin
              if (idx_ok) svr_q[idx] <= wd_q;
            end else begin
              case (addr_q)
                ADDR_IECR: en_q   <= en_q | m;
                ADDR_IDCR: en_q   <= en_q & ~m;
                ADDR_ICCR: pend_q <= pend_q & ~m;
                ADDR_ISCR: pend_q <= pend_q | m;
                ADDR_EOICR: begin
                  isr_q <= '0;
                  if (depth_q != '0) depth_q <= depth_q - DEPTH_W'(1);
                end
                ADDR_SPU:  spu_q  <= wd_q;
                ADDR_DCR:  dbg_q  <= wd_q[1];
                ADDR_FFER: fast_q <= fast_q | m;
                // source 0 stays fast
                ADDR_FFDR: fast_q <= fast_q & (~m | NUM_SRC'(1));
                default: ;
              endcase
            end
          end
          OP_LINE: begin
            if (src_ok) begin
              if (lvl_q) begin
                pend_q[src_q] <= 1'b1;
              end else if (smr_q[src_q][MODE_LEVEL_BIT]) begin
                pend_q[src_q] <= 1'b0;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire
